[rtl/nearest_neighbor_tour_unit_assert.svh]
// Assertion macros shared by the tour unit RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef NEAREST_NEIGHBOR_TOUR_UNIT_ASSERT_SVH
`define NEAREST_NEIGHBOR_TOUR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NNT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nearest neighbor tour unit: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define NNT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nearest neighbor tour unit: check failed");

`endif

[rtl/nnt_pkg.sv]
// Shared types and codes for the nearest-neighbour tour unit.
// No dependencies; imported by every module of the block.
package nnt_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_START    = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic [4:0]         start_index;
  } in_item_t;

  typedef struct packed {
    logic [4:0]         vertex_index;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic               last;
    logic [1:0]         error;
  } out_item_t;

  // Per-entry control that travels beside a point read out of the store.
  typedef struct packed {
    logic valid;
    logic live;
  } tag_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START_RD,
    ST_START_CAP,
    ST_EMIT_START,
    ST_SCAN,
    ST_EMIT_NEXT,
    ST_CLOSE,
    ST_ERROR
  } state_e;

endpackage

[rtl/nearest_neighbor_tour_unit.sv]
// Top level of the nearest-neighbour tour unit: sequencer, visited bits,
// best-candidate compare and output register. Uses nnt_pkg, nnt_point_mem,
// nnt_dist_pipe and the assertion macro header.
//
// Load and clear transactions are handled without leaving the idle state. A run
// over n loaded points streams every point through the single read port of the
// point memory once per tour position, then through a two-stage distance
// pipeline, and gives n + 1 results, the start point first and last. A start
// index not below the loaded count gives one error result. The input stalls
// while a run is in progress; a result waits in the output register and stalls
// the sequencer only when the next one is ready.
module nearest_neighbor_tour_unit import nnt_pkg::*; #(
  parameter int MAX_POINTS = 32,
  parameter int COORD_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

`include "nearest_neighbor_tour_unit_assert.svh"

  localparam int IdxW = $clog2(MAX_POINTS);
  localparam int CntW = $clog2(MAX_POINTS + 1);
  localparam int CmpW = (CntW > 5) ? CntW : 5;
  localparam int DstW = 2 * COORD_BITS + 1;

  state_e state_q, state_d;

  logic [CntW-1:0]       count_q, count_d;
  logic                  ovf_q, ovf_d;
  logic [MAX_POINTS-1:0] visited_q, visited_d;
  logic [1:0]            err_q, err_d;
  logic [IdxW-1:0]       start_q, start_d;
  logic [CntW-1:0]       step_q, step_d;
  logic [IdxW-1:0]       scan_idx_q, scan_idx_d;
  logic                  issue_done_q, issue_done_d;

  logic signed [COORD_BITS-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [COORD_BITS-1:0] start_x_q, start_x_d, start_y_q, start_y_d;

  logic                         have_q, have_d;
  logic [DstW-1:0]              best_d_q, best_d_d;
  logic [IdxW-1:0]              best_idx_q, best_idx_d;
  logic signed [COORD_BITS-1:0] best_x_q, best_x_d, best_y_q, best_y_d;

  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;
  logic      out_free;

  logic                         in_accept;
  logic                         mem_we;
  logic [IdxW-1:0]              mem_raddr;
  tag_t                         mem_rtag_in, mem_rtag;
  logic signed [COORD_BITS-1:0] mem_rx, mem_ry;
  logic [IdxW-1:0]              mem_ridx;

  tag_t                         tag_a, tag_b;
  logic [IdxW-1:0]              idx_b;
  logic signed [COORD_BITS-1:0] x_b, y_b;
  logic [2*COORD_BITS-1:0]      sqx_b, sqy_b;
  logic [DstW-1:0]              dist_b;
  logic                         pipe_empty;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign mem_we     = in_accept && (in_data_i.cmd == CMD_LOAD) &&
                      (count_q < CntW'(MAX_POINTS));
  assign dist_b     = DstW'(sqx_b) + DstW'(sqy_b);
  assign pipe_empty = !mem_rtag.valid && !tag_a.valid && !tag_b.valid;

  nnt_point_mem #(
    .DEPTH     (MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) u_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (mem_we),
    .waddr_i(IdxW'(count_q)),
    .wx_i   (COORD_BITS'(in_data_i.point_x)),
    .wy_i   (COORD_BITS'(in_data_i.point_y)),
    .raddr_i(mem_raddr),
    .rtag_i (mem_rtag_in),
    .rx_o   (mem_rx),
    .ry_o   (mem_ry),
    .ridx_o (mem_ridx),
    .rtag_o (mem_rtag)
  );

  nnt_dist_pipe #(
    .IDX_W     (IdxW),
    .COORD_BITS(COORD_BITS)
  ) u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (mem_rtag),
    .idx_i  (mem_ridx),
    .x_i    (mem_rx),
    .y_i    (mem_ry),
    .cur_x_i(cur_x_q),
    .cur_y_i(cur_y_q),
    .tag_a_o(tag_a),
    .tag_o  (tag_b),
    .idx_o  (idx_b),
    .x_o    (x_b),
    .y_o    (y_b),
    .sqx_o  (sqx_b),
    .sqy_o  (sqy_b)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    ovf_d        = ovf_q;
    visited_d    = visited_q;
    err_d        = err_q;
    start_d      = start_q;
    step_d       = step_q;
    scan_idx_d   = scan_idx_q;
    issue_done_d = issue_done_q;
    cur_x_d      = cur_x_q;
    cur_y_d      = cur_y_q;
    start_x_d    = start_x_q;
    start_y_d    = start_y_q;
    have_d       = have_q;
    best_d_d     = best_d_q;
    best_idx_d   = best_idx_q;
    best_x_d     = best_x_q;
    best_y_d     = best_y_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;
    mem_raddr    = scan_idx_q;
    mem_rtag_in  = '0;

    // Keep the nearest live candidate; strict compare leaves ties to the lower index.
    if (tag_b.valid && tag_b.live && (!have_q || dist_b < best_d_q)) begin
      have_d     = 1'b1;
      best_d_d   = dist_b;
      best_idx_d = idx_b;
      best_x_d   = x_b;
      best_y_d   = y_b;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (in_data_i.cmd)
            CMD_LOAD: begin
              if (count_q < CntW'(MAX_POINTS)) begin
                count_d = count_q + CntW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            CMD_CLEAR: begin
              count_d   = '0;
              visited_d = '0;
              ovf_d     = 1'b0;
            end
            CMD_RUN: begin
              err_d = ovf_q ? ERR_OVERFLOW : ERR_NONE;
              ovf_d = 1'b0;
              if (CmpW'(in_data_i.start_index) >= CmpW'(count_q)) begin
                state_d = ST_ERROR;
              end else begin
                start_d   = IdxW'(in_data_i.start_index);
                visited_d = '0;
                visited_d[IdxW'(in_data_i.start_index)] = 1'b1;
                state_d   = ST_START_RD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_START_RD: begin
        mem_raddr = start_q;
        state_d   = ST_START_CAP;
      end
      ST_START_CAP: begin
        cur_x_d   = mem_rx;
        cur_y_d   = mem_ry;
        start_x_d = mem_rx;
        start_y_d = mem_ry;
        state_d   = ST_EMIT_START;
      end
      ST_EMIT_START: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{vertex_index: 5'(start_q), out_x: 16'(start_x_q),
                          out_y: 16'(start_y_q), last: 1'b0, error: err_q};
          step_d      = '0;
          scan_idx_d  = '0;
          issue_done_d = 1'b0;
          have_d      = 1'b0;
          state_d     = (count_q == CntW'(1)) ? ST_CLOSE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!issue_done_q) begin
          mem_raddr        = scan_idx_q;
          mem_rtag_in.valid = 1'b1;
          mem_rtag_in.live  = !visited_q[scan_idx_q];
          if (scan_idx_q == IdxW'(count_q - CntW'(1))) begin
            issue_done_d = 1'b1;
          end else begin
            scan_idx_d = scan_idx_q + IdxW'(1);
          end
        end else if (pipe_empty) begin
          state_d = ST_EMIT_NEXT;
        end
      end
      ST_EMIT_NEXT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{vertex_index: 5'(best_idx_q), out_x: 16'(best_x_q),
                          out_y: 16'(best_y_q), last: 1'b0, error: err_q};
          visited_d[best_idx_q] = 1'b1;
          cur_x_d      = best_x_q;
          cur_y_d      = best_y_q;
          step_d       = step_q + CntW'(1);
          scan_idx_d   = '0;
          issue_done_d = 1'b0;
          have_d       = 1'b0;
          state_d      = (step_q + CntW'(1) == count_q - CntW'(1)) ? ST_CLOSE : ST_SCAN;
        end
      end
      ST_CLOSE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{vertex_index: 5'(start_q), out_x: 16'(start_x_q),
                          out_y: 16'(start_y_q), last: 1'b1, error: err_q};
          cur_x_d     = start_x_q;
          cur_y_d     = start_y_q;
          state_d     = ST_IDLE;
        end
      end
      ST_ERROR: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{vertex_index: 5'd0, out_x: 16'sd0, out_y: 16'sd0,
                          last: 1'b1, error: ERR_START};
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      ovf_q        <= 1'b0;
      visited_q    <= '0;
      issue_done_q <= 1'b0;
      have_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      cur_x_q      <= '0;
      cur_y_q      <= '0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      ovf_q        <= ovf_d;
      visited_q    <= visited_d;
      issue_done_q <= issue_done_d;
      have_q       <= have_d;
      out_valid_q  <= out_valid_d;
      cur_x_q      <= cur_x_d;
      cur_y_q      <= cur_y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q      <= err_d;
    start_q    <= start_d;
    step_q     <= step_d;
    scan_idx_q <= scan_idx_d;
    start_x_q  <= start_x_d;
    start_y_q  <= start_y_d;
    best_d_q   <= best_d_d;
    best_idx_q <= best_idx_d;
    best_x_q   <= best_x_d;
    best_y_q   <= best_y_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `NNT_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CntW'(MAX_POINTS))
  `NNT_ASSERT_NOW(a_error_is_last, clk_i, rst_ni,
                  out_valid_o && (out_data_o.error == ERR_START), out_data_o.last)
  `NNT_ASSERT_NOW(a_live_unvisited, clk_i, rst_ni,
                  tag_b.valid && tag_b.live, !visited_q[idx_b])
  `NNT_ASSERT_NOW(a_best_found, clk_i, rst_ni, state_q == ST_EMIT_NEXT, have_q)
  `NNT_ASSERT_NEXT(a_emit_marks, clk_i, rst_ni,
                   (state_q == ST_EMIT_NEXT) && out_free, visited_q[$past(best_idx_q)])

endmodule

[rtl/nnt_point_mem.sv]
// Point store: one synchronous memory of packed x/y coordinates.
// One write port, one read port with registered data and tag; uses nnt_pkg.
module nnt_point_mem import nnt_pkg::*; #(
  parameter int DEPTH      = 32,
  parameter int COORD_BITS = 16,
  localparam int IdxW      = $clog2(DEPTH)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         we_i,
  input  logic [IdxW-1:0]              waddr_i,
  input  logic signed [COORD_BITS-1:0] wx_i,
  input  logic signed [COORD_BITS-1:0] wy_i,
  input  logic [IdxW-1:0]              raddr_i,
  input  tag_t                         rtag_i,
  output logic signed [COORD_BITS-1:0] rx_o,
  output logic signed [COORD_BITS-1:0] ry_o,
  output logic [IdxW-1:0]              ridx_o,
  output tag_t                         rtag_o
);

  logic [2*COORD_BITS-1:0] mem_q [DEPTH];
  logic [2*COORD_BITS-1:0] rdata_q;
  logic [IdxW-1:0]         ridx_q;
  tag_t                    rtag_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= {wx_i, wy_i};
    end
    rdata_q <= mem_q[raddr_i];
    ridx_q  <= raddr_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rtag_q <= '0;
    end else begin
      rtag_q <= rtag_i;
    end
  end

  assign rx_o   = rdata_q[2*COORD_BITS-1:COORD_BITS];
  assign ry_o   = rdata_q[COORD_BITS-1:0];
  assign ridx_o = ridx_q;
  assign rtag_o = rtag_q;

endmodule

[rtl/nnt_dist_pipe.sv]
// Two-stage squared-distance pipeline: absolute differences, then squares.
// Carries the point's index and coordinates alongside; uses nnt_pkg.
module nnt_dist_pipe import nnt_pkg::*; #(
  parameter int IDX_W      = 5,
  parameter int COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tag_t                         tag_i,
  input  logic [IDX_W-1:0]             idx_i,
  input  logic signed [COORD_BITS-1:0] x_i,
  input  logic signed [COORD_BITS-1:0] y_i,
  input  logic signed [COORD_BITS-1:0] cur_x_i,
  input  logic signed [COORD_BITS-1:0] cur_y_i,
  output tag_t                         tag_a_o,
  output tag_t                         tag_o,
  output logic [IDX_W-1:0]             idx_o,
  output logic signed [COORD_BITS-1:0] x_o,
  output logic signed [COORD_BITS-1:0] y_o,
  output logic [2*COORD_BITS-1:0]      sqx_o,
  output logic [2*COORD_BITS-1:0]      sqy_o
);

  logic signed [COORD_BITS:0]   dx, dy;
  logic [COORD_BITS-1:0]        adx_d, ady_d, adx_q, ady_q;
  tag_t                         tag_a_q, tag_b_q;
  logic [IDX_W-1:0]             idx_a_q, idx_b_q;
  logic signed [COORD_BITS-1:0] x_a_q, y_a_q, x_b_q, y_b_q;
  logic [2*COORD_BITS-1:0]      sqx_q, sqy_q;

  always_comb begin
    dx    = (COORD_BITS+1)'(x_i) - (COORD_BITS+1)'(cur_x_i);
    dy    = (COORD_BITS+1)'(y_i) - (COORD_BITS+1)'(cur_y_i);
    adx_d = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
    ady_d = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_a_q <= '0;
      tag_b_q <= '0;
    end else begin
      tag_a_q <= tag_i;
      tag_b_q <= tag_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    adx_q   <= adx_d;
    ady_q   <= ady_d;
    idx_a_q <= idx_i;
    x_a_q   <= x_i;
    y_a_q   <= y_i;
    sqx_q   <= (2*COORD_BITS)'(adx_q) * (2*COORD_BITS)'(adx_q);
    sqy_q   <= (2*COORD_BITS)'(ady_q) * (2*COORD_BITS)'(ady_q);
    idx_b_q <= idx_a_q;
    x_b_q   <= x_a_q;
    y_b_q   <= y_a_q;
  end

  assign tag_a_o = tag_a_q;
  assign tag_o   = tag_b_q;
  assign idx_o   = idx_b_q;
  assign x_o     = x_b_q;
  assign y_o     = y_b_q;
  assign sqx_o   = sqx_q;
  assign sqy_o   = sqy_q;

endmodule

[dv/tb_nearest_neighbor_tour_unit.sv]
// Self-checking testbench for nearest_neighbor_tour_unit: directed and random
// load, run and clear transactions with a scoreboard that builds each tour.
// Depends on nnt_pkg and the RTL of the block.
`timescale 1ns / 1ps

import nnt_pkg::*;

class tour_scoreboard;
  localparam int MAX_PTS = 32;

  logic signed [15:0] pt_x [MAX_PTS];
  logic signed [15:0] pt_y [MAX_PTS];
  bit                 taken [MAX_PTS];
  int unsigned        n_pts;
  bit                 overflowed;
  out_item_t          tour_q [$];

  int unsigned checked;
  int unsigned mismatches;
  int unsigned runs;
  int unsigned start_errors;
  int unsigned overflow_runs;

  function new();
    n_pts      = 0;
    overflowed = 1'b0;
    foreach (taken[i]) taken[i] = 1'b0;
  endfunction

  function int pending();
    return tour_q.size();
  endfunction

  function longint unsigned sq_dist(int a, int b);
    longint span;
    span = a - b;
    return longint'(span * span);
  endfunction

  function void add_stop(logic [4:0] idx, logic signed [15:0] x, logic signed [15:0] y,
                         logic last, logic [1:0] err);
    out_item_t r;
    r.vertex_index = idx;
    r.out_x        = x;
    r.out_y        = y;
    r.last         = last;
    r.error        = err;
    tour_q.push_back(r);
  endfunction

  // Greedy tour from start: nearest unvisited point each step, lowest index on a tie.
  function void plan_tour(logic [4:0] start);
    logic [1:0]         err;
    logic signed [15:0] cx, cy;
    int                 best;
    bit                 have;
    longint unsigned    best_d, d;
    runs++;
    err = overflowed ? ERR_OVERFLOW : ERR_NONE;
    overflowed = 1'b0;
    if (start >= n_pts) begin
      start_errors++;
      add_stop('0, '0, '0, 1'b1, ERR_START);
      return;
    end
    if (err == ERR_OVERFLOW) overflow_runs++;
    foreach (taken[i]) taken[i] = 1'b0;
    taken[start] = 1'b1;
    cx = pt_x[start];
    cy = pt_y[start];
    add_stop(start, cx, cy, 1'b0, err);
    for (int s = 1; s < int'(n_pts); s++) begin
      have   = 1'b0;
      best   = 0;
      best_d = 0;
      for (int i = 0; i < int'(n_pts); i++) begin
        if (!taken[i]) begin
          d = sq_dist(pt_x[i], cx) + sq_dist(pt_y[i], cy);
          if (!have || d < best_d) begin
            have   = 1'b1;
            best_d = d;
            best   = i;
          end
        end
      end
      taken[best] = 1'b1;
      cx = pt_x[best];
      cy = pt_y[best];
      add_stop(5'(best), cx, cy, 1'b0, err);
    end
    add_stop(start, pt_x[start], pt_y[start], 1'b1, err);
  endfunction

  function void note_input(in_item_t it);
    case (it.cmd)
      CMD_LOAD: begin
        if (n_pts < MAX_PTS) begin
          pt_x[n_pts] = it.point_x;
          pt_y[n_pts] = it.point_y;
          n_pts++;
        end else begin
          overflowed = 1'b1;
        end
      end
      CMD_CLEAR: begin
        n_pts      = 0;
        overflowed = 1'b0;
        foreach (taken[i]) taken[i] = 1'b0;
      end
      CMD_RUN: plan_tour(it.start_index);
      default: ;
    endcase
  endfunction

  function void flag_result(string why, out_item_t got, out_item_t want);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected idx %0d x %0d y %0d last %0b err %0d, %s",
               why, want.vertex_index, want.out_x, want.out_y, want.last, want.error,
               $sformatf("got idx %0d x %0d y %0d last %0b err %0d", got.vertex_index,
                         got.out_x, got.out_y, got.last, got.error));
  endfunction

  function void check_result(out_item_t got);
    out_item_t want;
    bit        bad;
    if (tour_q.size() == 0) begin
      flag_result("unexpected tour result", got, '0);
      return;
    end
    want = tour_q.pop_front();
    checked++;
    bad = (got.vertex_index !== want.vertex_index) || (got.out_x !== want.out_x) ||
          (got.out_y !== want.out_y) || (got.last !== want.last) ||
          (got.error !== want.error);
    if (bad) flag_result("tour result mismatch", got, want);
  endfunction
endclass

module tb_nearest_neighbor_tour_unit;
  localparam int MAX_PTS       = 32;
  localparam int ITEM_TARGET   = 250;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 1300;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  tour_scoreboard sb = new();

  int send_idle_pct = 28;
  int stall_pct     = 77;
  int sent_items    = 0;
  int total_xfers   = 0;
  int cycle_count   = 0;
  int hold_left     = 0;
  bit hold_req      = 1'b0;
  bit hold_taken    = 1'b0;

  nearest_neighbor_tour_unit u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d tour results outstanding",
               cycle_count, sb.pending());
      $display("nearest_neighbor_tour_unit regression: fail");
      $finish;
    end
  end

  // Receiver: check each accepted result, then choose the stall for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic in_item_t make_item(logic [1:0] cmd, logic signed [15:0] x,
                                         logic signed [15:0] y, logic [4:0] start);
    in_item_t it;
    it.cmd         = cmd;
    it.point_x     = x;
    it.point_y     = y;
    it.start_index = start;
    return it;
  endfunction

  // 0: anywhere, 1: tight cluster so ties are common, 2: both ends of the range, zero and -1
  function automatic logic signed [15:0] pick_coord(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'(int'($urandom_range(6)) - 3);
      default: begin
        case ($urandom_range(3))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
    endcase
  endfunction

  // Hold valid across back-to-back transactions; lower it only for a gap.
  task automatic send_item(input in_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 12) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
    total_xfers++;
    if (it.cmd != CMD_UNUSED) sent_items++;
  endtask

  task automatic settle_outputs();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic directed_items();
    send_item(make_item(CMD_RUN, '0, '0, 5'd0));
    send_item(make_item(CMD_UNUSED, 16'sh7fff, 16'sh8000, 5'd31));
    send_item(make_item(CMD_LOAD, 16'sh8000, 16'sh8000, 5'd0));
    send_item(make_item(CMD_LOAD, 16'sh7fff, 16'sh7fff, 5'd31));
    send_item(make_item(CMD_LOAD, 16'sh0000, 16'sh0000, 5'd0));
    send_item(make_item(CMD_LOAD, 16'sh7fff, 16'sh8000, 5'd0));
    send_item(make_item(CMD_RUN, '0, '0, 5'd0));
    send_item(make_item(CMD_RUN, '0, '0, 5'd3));
    send_item(make_item(CMD_RUN, '0, '0, 5'd4));
    send_item(make_item(CMD_RUN, '0, '0, 5'd31));
    // single point: start, then start again
    send_item(make_item(CMD_CLEAR, '0, '0, '0));
    send_item(make_item(CMD_LOAD, 16'sd5, -16'sd5, 5'd0));
    send_item(make_item(CMD_RUN, '0, '0, 5'd0));
    // four neighbours at the same distance, one of them a duplicate
    send_item(make_item(CMD_CLEAR, '0, '0, '0));
    send_item(make_item(CMD_LOAD, 16'sd0, 16'sd0, 5'd0));
    send_item(make_item(CMD_LOAD, 16'sd1, 16'sd0, 5'd0));
    send_item(make_item(CMD_LOAD, -16'sd1, 16'sd0, 5'd0));
    send_item(make_item(CMD_LOAD, 16'sd0, 16'sd1, 5'd0));
    send_item(make_item(CMD_LOAD, 16'sd1, 16'sd0, 5'd0));
    send_item(make_item(CMD_RUN, '0, '0, 5'd0));
    send_item(make_item(CMD_RUN, '0, '0, 5'd4));
    send_item(make_item(CMD_CLEAR, '0, '0, '0));
    send_item(make_item(CMD_RUN, '0, '0, 5'd0));
  endtask

  // Mostly clear/load/run sequences with random content, some plain noise.
  task automatic random_sequence(input bit force_overflow);
    int         n, mode, have;
    logic [4:0] start;
    if (!force_overflow && $urandom_range(99) < 20) begin
      repeat ($urandom_range(4, 1))
        send_item(make_item(2'($urandom_range(3)), 16'($urandom), 16'($urandom),
                            5'($urandom_range(31))));
      return;
    end
    n = $urandom_range(99);
    if (force_overflow) n = MAX_PTS + 2;
    else if (n < 6) n = MAX_PTS + $urandom_range(3);
    else if (n < 14) n = $urandom_range(20, 9);
    else n = $urandom_range(8, 1);
    mode = $urandom_range(2);
    // keep the old store now and then, so new points stack on top of it
    if (force_overflow || $urandom_range(4) != 0)
      send_item(make_item(CMD_CLEAR, 16'($urandom), 16'($urandom), 5'($urandom)));
    repeat (n)
      send_item(make_item(CMD_LOAD, pick_coord(mode), pick_coord(mode), 5'($urandom)));
    repeat ($urandom_range(3, 1)) begin
      have = sb.n_pts;
      if (have == 0) start = 5'($urandom_range(31));
      else if (have < MAX_PTS && $urandom_range(99) < 15) start = 5'($urandom_range(31, have));
      else if ($urandom_range(3) == 0) start = 5'(have - 1);
      else start = 5'($urandom_range(have - 1));
      // long receiver hold-off while further transactions queue up behind this run
      if (sent_items > 40) hold_req = 1'b1;
      send_item(make_item(CMD_RUN, 16'($urandom), 16'($urandom), start));
    end
  endtask

  initial begin
    int  phase, cur_phase;
    bit  first;
    cur_phase = 0;
    first     = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_items();
    while (sent_items < ITEM_TARGET) begin
      phase = sent_items * 3 / ITEM_TARGET;
      if (phase != cur_phase) begin
        settle_outputs();
        cur_phase = phase;
        if (phase == 1) begin
          send_idle_pct = 77;
          stall_pct     = 28;
        end else begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
      end
      random_sequence(first);
      first = 1'b0;
    end
    settle_outputs();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0) $display("%0d tour results never arrived", sb.pending());
    $display("%0d transactions driven, %0d runs (%0d bad starts, %0d after overflow)",
             total_xfers, sb.runs, sb.start_errors, sb.overflow_runs);
    $display("%0d tour results checked, %0d mismatches, %0d cycles",
             sb.checked, sb.mismatches, cycle_count);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("nearest_neighbor_tour_unit regression: pass");
    end else begin
      $display("nearest_neighbor_tour_unit regression: fail");
    end
    $finish;
  end
endmodule
